### rtl/mft_pkg.sv
// ----------------------------------------------------------------------------
// mft_pkg
// Shared constants and types for the Manchester frame transmitter.
// ----------------------------------------------------------------------------
package mft_pkg;

  // Request opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Bit positions within the 22-bit two-frame sequence
  localparam logic [4:0] POS_START0_A = 5'd0;
  localparam logic [4:0] POS_START0_B = 5'd1;
  localparam logic [4:0] POS_STOP0    = 5'd10;
  localparam logic [4:0] POS_START1_A = 5'd11;
  localparam logic [4:0] POS_START1_B = 5'd12;
  localparam logic [4:0] POS_STOP1    = 5'd21;
  localparam logic [4:0] POS_END      = 5'd22;

  // Bit source decision for the current half-bit
  typedef struct packed {
    logic end_seq;    // position past the last bit: finish transmission
    logic take_data;  // fetch the next data bit and advance the index
    logic bit_val;    // bit value to encode on this half
  } mft_bit_t;

endpackage

### rtl/mft_bit_source.sv
// ----------------------------------------------------------------------------
// mft_bit_source
// Picks the bit to encode for the current position: start ones, stop zeros
// or the next data bit of the stored word; flags the end past the last bit.
// ----------------------------------------------------------------------------
module mft_bit_source
  import mft_pkg::*;
(
  input  logic [4:0]  bit_position,
  input  logic        second_half,
  input  logic [3:0]  data_index,
  input  logic        data_bit,
  input  logic [15:0] word_store,
  output mft_bit_t    bit_info
);

  // Framing or data decision by position
  always_comb begin
    bit_info = '0;
    if (bit_position >= POS_END) begin
      bit_info.end_seq = 1'b1;
    end else if (bit_position == POS_START0_A || bit_position == POS_START0_B ||
                 bit_position == POS_START1_A || bit_position == POS_START1_B) begin
      bit_info.bit_val = 1'b1;
    end else if (bit_position == POS_STOP0 || bit_position == POS_STOP1) begin
      bit_info.bit_val = 1'b0;
    end else if (!second_half) begin
      // first half fetches a fresh data bit
      bit_info.take_data = 1'b1;
      bit_info.bit_val   = word_store[data_index];
    end else begin
      bit_info.bit_val = data_bit;
    end
  end

endmodule

### rtl/manchester_frame_transmitter.sv
// ----------------------------------------------------------------------------
// manchester_frame_transmitter
// Sends a 16-bit word as two Manchester-coded frames, one tick per half bit.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | opcode, data_word
//  out     | out_valid / out_stall| line_level, busy_res, frame_done
//
// One request is taken per cycle while in_stall is low; its result appears
// in the output register on the next cycle. The state update between
// request and result register is combinational. in_stall is raised only
// while the output register holds a result that is itself stalled.
// Synchronous reset clears the state and empties the output register.
module manchester_frame_transmitter
  import mft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_level,
  output logic        busy_res,
  output logic        frame_done
);

  logic        active, active_next;
  logic [4:0]  bit_position, bit_position_next;
  logic        second_half, second_half_next;
  logic [3:0]  data_index, data_index_next;
  logic        data_bit, data_bit_next;
  logic [15:0] word_store, word_store_next;
  logic        line_out, line_out_next;
  logic        done_next;
  logic        accept;
  mft_bit_t    bit_info;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  mft_bit_source u_bit_source (
    .bit_position (bit_position),
    .second_half  (second_half),
    .data_index   (data_index),
    .data_bit     (data_bit),
    .word_store   (word_store),
    .bit_info     (bit_info)
  );

  // Next state for one request
  always_comb begin
    active_next       = active;
    bit_position_next = bit_position;
    second_half_next  = second_half;
    data_index_next   = data_index;
    data_bit_next     = data_bit;
    word_store_next   = word_store;
    line_out_next     = line_out;
    done_next         = 1'b0;
    if (opcode == OP_START) begin
      if (!active) begin
        word_store_next   = data_word;
        active_next       = 1'b1;
        bit_position_next = '0;
        second_half_next  = 1'b0;
        data_index_next   = '0;
      end
    end else if (active) begin
      if (bit_info.end_seq) begin
        line_out_next     = 1'b0;
        active_next       = 1'b0;
        bit_position_next = '0;
        second_half_next  = 1'b0;
        data_index_next   = '0;
        done_next         = 1'b1;
      end else begin
        if (bit_info.take_data) begin
          data_bit_next   = bit_info.bit_val;
          data_index_next = data_index + 4'd1;
        end
        // inverted bit first, true bit second
        if (!second_half) begin
          line_out_next    = ~bit_info.bit_val;
          second_half_next = 1'b1;
        end else begin
          line_out_next     = bit_info.bit_val;
          second_half_next  = 1'b0;
          bit_position_next = bit_position + 5'd1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      bit_position <= '0;
      second_half  <= 1'b0;
      data_index   <= '0;
      data_bit     <= 1'b0;
      word_store   <= '0;
      line_out     <= 1'b0;
    end else if (accept) begin
      active       <= active_next;
      bit_position <= bit_position_next;
      second_half  <= second_half_next;
      data_index   <= data_index_next;
      data_bit     <= data_bit_next;
      word_store   <= word_store_next;
      line_out     <= line_out_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_level <= line_out_next;
      busy_res   <= active_next;
      frame_done <= done_next;
    end
  end

endmodule

### rtl/mft_checker.sv
// ----------------------------------------------------------------------------
// mft_port_checks
// Port-level checks for the Manchester frame transmitter.
// ----------------------------------------------------------------------------
module mft_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        opcode,
  input logic [15:0] data_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic        line_level,
  input logic        busy_res,
  input logic        frame_done
);

  // End of transmission leaves the line low and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> !line_level && !busy_res)
    else $error("frame_done with line high or still busy");

  // Requests are held back only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_level) &&
      $stable(busy_res) && $stable(frame_done))
    else $error("stalled result changed");

  // A stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(data_word))
    else $error("stalled request changed");

endmodule

bind manchester_frame_transmitter mft_port_checks u_mft_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .opcode     (opcode),
  .data_word  (data_word),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .line_level (line_level),
  .busy_res   (busy_res),
  .frame_done (frame_done)
);
